// ----- design/owsr_pkg.sv -----
// shared types, constants and helpers for the omni wheel speed ramp
`default_nettype none

package owsr_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_W     = 31;
    localparam int unsigned SPAN_W    = 47;
    localparam int unsigned LIM_W     = 47;
    localparam int unsigned SUM_W     = 49;
    localparam int unsigned SPLIT_W   = 24;
    localparam int unsigned MUL_W     = 57;
    localparam int unsigned ACC_W     = 80;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned WIDE_W    = 64;
    localparam int unsigned ADDR_W    = 3;

    // register indexes on the config port
    localparam logic [ADDR_W-1:0] CFG_UPDATE_PERIOD = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_MAX_ACCEL     = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_HALF_SPAN     = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_SPEED_SCALE   = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_SETTLE_TOL    = 3'd4;

    localparam logic [WORD_W-1:0] RST_UPDATE_PERIOD = 32'd3277;
    localparam logic [CFG_W-1:0]  RST_MAX_ACCEL     = 31'd0;
    localparam logic [CFG_W-1:0]  RST_HALF_SPAN     = 31'd22282;
    localparam logic [CFG_W-1:0]  RST_SPEED_SCALE   = 31'd873813;
    localparam logic [CFG_W-1:0]  RST_SETTLE_TOL    = 31'd655;

    // wheel order: north, west, south, east
    localparam logic [NUM_LANES-1:0] LANE_SUB_VY   = 4'b1010;
    localparam logic [NUM_LANES-1:0] LANE_SUB_SPAN = 4'b0011;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sd2147483648;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic sum_en;
        logic mlo_en;
        logic mhi_en;
        logic err_en;
        logic chk_en;
        logic commit;
    } t_lane_ctl;

    typedef struct packed {
        logic  settled;
        t_word ramp_next;
        t_word pass;
    } t_lane_res;

    function automatic t_word sat32(input t_wide v);
        t_word r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/omni_wheel_speed_ramp_top.sv -----
// top level of the four wheel omni inverse kinematics with wheel slew limit
// a handled request walks the gate, sum, low and high multiply, error, clamp and merge states
//   before it shows on m_axis_tvalid; merge holds while the output register is full
// a new request is taken only back in idle; a too-early request is dropped at the gate
// the output register lets the next request start while a result waits
// reset (synchronous, i_rst_n low) clears control, ramp commands and last time
`default_nettype none

module omni_wheel_speed_ramp_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config write port
    input  wire logic                         i_cfg_we,
    input  wire logic [owsr_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [owsr_pkg::WORD_W-1:0]  i_cfg_wdata,
    // request stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // time_now, target_vx, target_vy, target_rot,
    // meas_north, meas_west, meas_south, meas_east (32 bits each)
    input  wire logic [8*owsr_pkg::WORD_W-1:0] s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // drive_north, drive_west, drive_south, drive_east (32 bits each)
    output logic [owsr_pkg::NUM_LANES*owsr_pkg::WORD_W-1:0] m_axis_tdata,
    // ramping
    output logic                              m_axis_tuser
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_GATE  = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MLO   = 3'd3;
    localparam logic [2:0] ST_MHI   = 3'd4;
    localparam logic [2:0] ST_ERR   = 3'd5;
    localparam logic [2:0] ST_CHK   = 3'd6;
    localparam logic [2:0] ST_MERGE = 3'd7;

    // config registers
    logic [owsr_pkg::WORD_W-1:0] r_update_period;
    logic [owsr_pkg::CFG_W-1:0]  r_max_accel;
    logic [owsr_pkg::CFG_W-1:0]  r_half_span;
    logic [owsr_pkg::CFG_W-1:0]  r_speed_scale;
    logic [owsr_pkg::CFG_W-1:0]  r_settle_tol;

    // request capture
    logic [owsr_pkg::WORD_W-1:0] r_time;
    logic [owsr_pkg::WORD_W-1:0] r_elapsed;
    owsr_pkg::t_word             r_vx;
    owsr_pkg::t_word             r_vy;
    owsr_pkg::t_word             r_rot;
    owsr_pkg::t_word             r_meas [owsr_pkg::NUM_LANES];

    // shared terms
    logic signed [owsr_pkg::SPAN_W-1:0] r_span;
    logic [owsr_pkg::LIM_W-1:0]         r_limit;

    // control state
    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [owsr_pkg::WORD_W-1:0] r_last;

    logic                        w_accept;
    logic                        w_too_early;
    logic signed [2*owsr_pkg::WORD_W-1:0] w_span_prod;
    logic [owsr_pkg::WORD_W+owsr_pkg::CFG_W-1:0] w_lim_prod;
    owsr_pkg::t_lane_ctl         w_ctl;
    owsr_pkg::t_lane_res         w_res [owsr_pkg::NUM_LANES];
    logic                        w_free;
    logic                        w_load;
    logic                        w_commit;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_too_early   = (r_elapsed < r_update_period);
    assign w_load        = (r_state == ST_MERGE) && w_free;

    // config writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_period <= owsr_pkg::RST_UPDATE_PERIOD;
            r_max_accel     <= owsr_pkg::RST_MAX_ACCEL;
            r_half_span     <= owsr_pkg::RST_HALF_SPAN;
            r_speed_scale   <= owsr_pkg::RST_SPEED_SCALE;
            r_settle_tol    <= owsr_pkg::RST_SETTLE_TOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                owsr_pkg::CFG_UPDATE_PERIOD: begin
                    r_update_period <= i_cfg_wdata;
                end
                owsr_pkg::CFG_MAX_ACCEL: begin
                    r_max_accel <= i_cfg_wdata[owsr_pkg::CFG_W-1:0];
                end
                owsr_pkg::CFG_HALF_SPAN: begin
                    r_half_span <= i_cfg_wdata[owsr_pkg::CFG_W-1:0];
                end
                owsr_pkg::CFG_SPEED_SCALE: begin
                    r_speed_scale <= i_cfg_wdata[owsr_pkg::CFG_W-1:0];
                end
                owsr_pkg::CFG_SETTLE_TOL: begin
                    r_settle_tol <= i_cfg_wdata[owsr_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // capture the request and its elapsed time (wraps modulo 2^32)
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time    <= s_axis_tdata[0 +: owsr_pkg::WORD_W];
            r_elapsed <= s_axis_tdata[0 +: owsr_pkg::WORD_W] - r_last;
            r_vx      <= s_axis_tdata[1*owsr_pkg::WORD_W +: owsr_pkg::WORD_W];
            r_vy      <= s_axis_tdata[2*owsr_pkg::WORD_W +: owsr_pkg::WORD_W];
            r_rot     <= s_axis_tdata[3*owsr_pkg::WORD_W +: owsr_pkg::WORD_W];
            for (int i = 0; i < owsr_pkg::NUM_LANES; i++) begin
                r_meas[i] <= s_axis_tdata[(4+i)*owsr_pkg::WORD_W +: owsr_pkg::WORD_W];
            end
        end
    end

    // span = floor(rot * half_span / 2^16), limit = floor(accel * elapsed / 2^16)
    assign w_span_prod = r_rot * $signed({1'b0, r_half_span});
    assign w_lim_prod  = r_max_accel * r_elapsed;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_GATE) begin
            r_span  <= w_span_prod[owsr_pkg::FRAC_W+owsr_pkg::SPAN_W-1:owsr_pkg::FRAC_W];
            r_limit <= w_lim_prod[owsr_pkg::FRAC_W+owsr_pkg::LIM_W-1:owsr_pkg::FRAC_W];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_GATE;
                end
            end
            ST_GATE: begin
                // too early: drop the request; time base and ramp commands stay unchanged
                n_state = w_too_early ? ST_IDLE : ST_SUM;
            end
            ST_SUM:   n_state = ST_MLO;
            ST_MLO:   n_state = ST_MHI;
            ST_MHI:   n_state = ST_ERR;
            ST_ERR:   n_state = ST_CHK;
            ST_CHK:   n_state = ST_MERGE;
            ST_MERGE: begin
                // hold until the output register has room
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_last <= r_time;
            end
        end
    end

    // lane strobes
    always_comb begin
        w_ctl.sum_en = (r_state == ST_SUM);
        w_ctl.mlo_en = (r_state == ST_MLO);
        w_ctl.mhi_en = (r_state == ST_MHI);
        w_ctl.err_en = (r_state == ST_ERR);
        w_ctl.chk_en = (r_state == ST_CHK);
        w_ctl.commit = w_commit;
    end

    // one lane per wheel: north, west, south, east
    for (genvar g = 0; g < owsr_pkg::NUM_LANES; g++) begin : g_lane
        owsr_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_sub_vy   (owsr_pkg::LANE_SUB_VY[g]),
            .i_sub_span (owsr_pkg::LANE_SUB_SPAN[g]),
            .i_vx       (r_vx),
            .i_vy       (r_vy),
            .i_span     (r_span),
            .i_scale    (r_speed_scale),
            .i_meas     (r_meas[g]),
            .i_tol      (r_settle_tol),
            .i_limit    (r_limit),
            .o_res      (w_res[g])
        );
    end

    // pass-through vs ramp choice and result register
    owsr_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (w_res),
        .i_accel_zero (r_max_accel == '0),
        .i_load       (w_load),
        .o_free       (w_free),
        .o_commit     (w_commit),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser)
    );

    // ramp commands only move when a result is loaded
    a_commit_in_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (r_state == ST_MERGE))
        else $error("ramp commit outside merge state");

    // a too-early request leaves the time base alone and returns to idle
    a_early_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GATE && w_too_early) |=> ($stable(r_last) && r_state == ST_IDLE))
        else $error("too-early request was not dropped cleanly");

    // a result appears only right after the merge step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_MERGE))
        else $error("result valid without a merge step");

endmodule

`default_nettype wire

// ----- design/owsr_lane.sv -----
// one wheel lane: speed sum, split scale multiply, error, clamp and ramp command
`default_nettype none

module owsr_lane (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire owsr_pkg::t_lane_ctl                  i_ctl,
    input  wire logic                                 i_sub_vy,
    input  wire logic                                 i_sub_span,
    input  wire owsr_pkg::t_word                      i_vx,
    input  wire owsr_pkg::t_word                      i_vy,
    input  wire logic signed [owsr_pkg::SPAN_W-1:0]   i_span,
    input  wire logic [owsr_pkg::CFG_W-1:0]           i_scale,
    input  wire owsr_pkg::t_word                      i_meas,
    input  wire logic [owsr_pkg::CFG_W-1:0]           i_tol,
    input  wire logic [owsr_pkg::LIM_W-1:0]           i_limit,
    output owsr_pkg::t_lane_res                       o_res
);

    logic signed [owsr_pkg::SUM_W-1:0]  r_sum;
    logic signed [owsr_pkg::ACC_W-1:0]  r_acc;
    owsr_pkg::t_wide                    r_err;
    owsr_pkg::t_word                    r_pass;
    owsr_pkg::t_word                    r_ramp;
    owsr_pkg::t_word                    r_ramp_next;
    logic                               r_settled;

    logic signed [owsr_pkg::SUM_W-1:0]  w_vx_ext;
    logic signed [owsr_pkg::SUM_W-1:0]  w_vy_ext;
    logic signed [owsr_pkg::SUM_W-1:0]  w_span_ext;
    logic signed [owsr_pkg::SUM_W-1:0]  n_sum;
    logic signed [owsr_pkg::SUM_W-owsr_pkg::SPLIT_W-1:0] w_mul_a;
    logic signed [owsr_pkg::WORD_W-1:0] w_scale;
    logic signed [owsr_pkg::MUL_W-1:0]  w_prod;
    logic signed [owsr_pkg::ACC_W-1:0]  w_prod_ext;
    owsr_pkg::t_wide                    w_desired;
    owsr_pkg::t_wide                    w_tol;
    owsr_pkg::t_wide                    w_lim;
    owsr_pkg::t_wide                    w_step;
    logic                               w_settled;

    // wheel sum: vx +/- vy +/- span
    always_comb begin
        w_vx_ext   = owsr_pkg::SUM_W'(i_vx);
        w_vy_ext   = owsr_pkg::SUM_W'(i_vy);
        w_span_ext = owsr_pkg::SUM_W'(i_span);
        n_sum = w_vx_ext + (i_sub_vy ? -w_vy_ext : w_vy_ext)
                         + (i_sub_span ? -w_span_ext : w_span_ext);
    end

    // one 25x32 multiplier, low half of the sum first, then the signed high half
    always_comb begin
        w_mul_a = i_ctl.mhi_en ? $signed(r_sum[owsr_pkg::SUM_W-1:owsr_pkg::SPLIT_W])
                               : $signed({1'b0, r_sum[owsr_pkg::SPLIT_W-1:0]});
        w_scale    = $signed({1'b0, i_scale});
        w_prod     = w_mul_a * w_scale;
        w_prod_ext = owsr_pkg::ACC_W'(w_prod);
        w_desired  = $signed(r_acc[owsr_pkg::ACC_W-1:owsr_pkg::FRAC_W]);
    end

    // settle test and slew clamp
    always_comb begin
        w_tol     = $signed({{(owsr_pkg::WIDE_W-owsr_pkg::CFG_W){1'b0}}, i_tol});
        w_lim     = $signed({{(owsr_pkg::WIDE_W-owsr_pkg::LIM_W){1'b0}}, i_limit});
        w_settled = (r_err < w_tol) && (r_err > -w_tol);
        if (r_err >= 0) begin
            w_step = (r_err < w_lim) ? r_err : w_lim;
        end else begin
            w_step = (r_err > -w_lim) ? r_err : -w_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
        if (i_ctl.mlo_en) begin
            r_acc <= w_prod_ext;
        end else if (i_ctl.mhi_en) begin
            r_acc <= r_acc + (w_prod_ext <<< owsr_pkg::SPLIT_W);
        end
        if (i_ctl.err_en) begin
            r_err  <= w_desired - owsr_pkg::WIDE_W'(i_meas);
            r_pass <= owsr_pkg::sat32(w_desired);
        end
        if (i_ctl.chk_en) begin
            r_settled   <= w_settled;
            r_ramp_next <= owsr_pkg::sat32(owsr_pkg::WIDE_W'(r_ramp) + w_step);
        end
    end

    // stored ramp command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp <= '0;
        end else if (i_ctl.commit) begin
            r_ramp <= r_ramp_next;
        end
    end

    assign o_res = '{settled: r_settled, ramp_next: r_ramp_next, pass: r_pass};

endmodule

`default_nettype wire

// ----- design/owsr_merge.sv -----
// merge of the lane results: mode choice and output register
`default_nettype none

module owsr_merge (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire owsr_pkg::t_lane_res          i_res [owsr_pkg::NUM_LANES],
    input  wire logic                         i_accel_zero,
    input  wire logic                         i_load,
    output logic                              o_free,
    output logic                              o_commit,
    output logic                              o_tvalid,
    input  wire logic                         i_tready,
    output logic [owsr_pkg::NUM_LANES*owsr_pkg::WORD_W-1:0] o_tdata,
    output logic                              o_tuser
);

    logic                                                r_valid;
    logic [owsr_pkg::NUM_LANES*owsr_pkg::WORD_W-1:0]     r_data;
    logic                                                r_user;
    logic [owsr_pkg::NUM_LANES*owsr_pkg::WORD_W-1:0]     n_data;
    logic                                                w_all_settled;
    logic                                                w_ramping;

    always_comb begin
        w_all_settled = 1'b1;
        for (int i = 0; i < owsr_pkg::NUM_LANES; i++) begin
            w_all_settled = w_all_settled & i_res[i].settled;
        end
        w_ramping = !i_accel_zero && !w_all_settled;
        for (int i = 0; i < owsr_pkg::NUM_LANES; i++) begin
            n_data[i*owsr_pkg::WORD_W +: owsr_pkg::WORD_W] =
                w_ramping ? i_res[i].ramp_next : i_res[i].pass;
        end
    end

    assign o_free   = !r_valid || i_tready;
    assign o_commit = i_load && w_ramping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
            r_user <= w_ramping;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;

endmodule

`default_nettype wire
